// ----- rtl/fenwick_tree_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Fenwick tree engine assertion macros
// Shared same-cycle and next-cycle implication checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FENWICK_TREE_ENGINE_DEFINES_SVH
`define FENWICK_TREE_ENGINE_DEFINES_SVH

// cons must hold in the same cycle as ante
`define FTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define FTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fte_pkg.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree engine package
// Item types, command codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package fte_pkg;

    localparam int POS_BITS = 11;
    localparam int IN_WEIGHT_BITS = 48;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_SUM  = 2'd1;
    localparam logic [1:0] CMD_FIND = 2'd2;

    typedef struct packed {
        logic        [1:0]                command;
        logic        [POS_BITS-1:0]       position;
        logic        [POS_BITS-1:0]       limit;
        logic signed [IN_WEIGHT_BITS-1:0] delta;
        logic signed [IN_WEIGHT_BITS-1:0] target;
    } in_item_t;

    typedef struct packed {
        logic signed [IN_WEIGHT_BITS-1:0] prefix_total;
        logic        [POS_BITS-1:0]       found_position;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_ADD,
        ST_FIND_INIT,
        ST_FIND,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/fte_ram.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree node memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fte_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fenwick_tree_engine.sv -----
// ----------------------------------------------------------------------------
// Fenwick tree engine
// Binary indexed tree of signed node sums held in one synchronous memory;
// serves add, prefix-sum and find commands one item at a time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in        in   in_valid/in_ready    in_item  (command, position, limit,
//                                                delta, target)
//  out       out  out_valid/out_ready  out_item (prefix_total, found_position)
//
//  Walks: one node per cycle through the memory read port. Add and sum step
//  through their nodes from the accepted position; find first sets its step
//  to the highest power of two not above the limit, then halves it per node.
//  Reset: a clearing pass writes zero to every node, with in_ready low
//  throughout.
//  Stalls: the result sits in an output register; a held result only blocks
//  completion of the following item, not its acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fenwick_tree_engine_defines.svh"

module fenwick_tree_engine
    import fte_pkg::*;
#(
    parameter int ENTRIES     = 1024,
    parameter int WEIGHT_BITS = 48
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    // node numbers run 1..ENTRIES; walks may overshoot to 2*ENTRIES
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PW    = $clog2(ENTRIES) + 2;
    localparam int CW    = (PW > POS_BITS) ? PW : POS_BITS;

    state_t state_reg, state_next;

    logic [1:0]                    cmd_reg, cmd_next;
    logic                          pend_reg, pend_next;
    logic [PW-1:0]                 node_reg, node_next;
    logic [PW-1:0]                 wr_node_reg, wr_node_next;
    logic [PW-1:0]                 lim_reg, lim_next;
    logic [PW-1:0]                 step_reg, step_next;
    logic [PW-1:0]                 at_reg, at_next;
    logic [PW-1:0]                 cand_reg, cand_next;
    logic                          cand_ok_reg, cand_ok_next;
    logic signed [WEIGHT_BITS-1:0] acc_reg, acc_next;
    logic signed [WEIGHT_BITS-1:0] delta_reg, delta_next;
    logic signed [WEIGHT_BITS-1:0] want_reg, want_next;
    logic [IDX_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    out_item_t                     out_item_reg, out_item_next;

    // memory ports
    logic                          rd_en;
    logic [PW-1:0]                 rd_node;
    logic [IDX_W-1:0]              rd_addr;
    logic signed [WEIGHT_BITS-1:0] rd_data;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [WEIGHT_BITS-1:0]        wr_data;

    // input decode
    logic [CW-1:0] pos_wide;
    logic [CW-1:0] lim_wide;
    logic          pos_over;
    logic [PW-1:0] pos_c;
    logic [PW-1:0] lim_c;
    logic          add_ok;
    logic          accept;

    // walk helpers
    logic          node_in_lim;
    logic          take;
    logic [PW-1:0] at_plus;
    logic [PW-1:0] cand_plus;
    logic [PW-1:0] msb_smear;
    logic [PW-1:0] lim_msb;
    logic          result_load;

    fte_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WEIGHT_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Input clamping: positions and limits saturate at ENTRIES
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_wide = CW'(in_item.position);
        lim_wide = CW'(in_item.limit);
        pos_over = pos_wide > CW'(ENTRIES);
        pos_c    = pos_over ? PW'(ENTRIES) : PW'(pos_wide);
        lim_c    = (lim_wide > CW'(ENTRIES)) ? PW'(ENTRIES) : PW'(lim_wide);
        // add at position zero or beyond the tree changes nothing
        add_ok   = !pos_over && (pos_c != '0);
    end

    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;
    assign result_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // Highest power of two not above the limit: smear right, keep top bit
    // ------------------------------------------------------------------
    always_comb
    begin
        msb_smear = lim_reg;
        for (int s = 1; s < PW; s = s * 2)
        begin
            msb_smear = msb_smear | (msb_smear >> s);
        end
        lim_msb = msb_smear & ~(msb_smear >> 1);
    end

    // ------------------------------------------------------------------
    // Walk helpers
    // ------------------------------------------------------------------
    always_comb
    begin
        node_in_lim = (node_reg <= lim_reg);
        // find: take the node read last cycle if it lies within the limit
        // and its sum is still below the residual target
        take        = pend_reg && cand_ok_reg && (rd_data < want_reg);
        at_plus     = at_reg + step_reg;
        cand_plus   = cand_reg + step_reg;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.command)
                        CMD_ADD:  state_next = add_ok ? ST_ADD : ST_DONE;
                        CMD_SUM:  state_next = ST_SUM;
                        CMD_FIND: state_next = ST_FIND_INIT;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_SUM:
            begin
                if ((node_reg == '0) && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ADD:
            begin
                if (!node_in_lim && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIND_INIT:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if ((step_reg == '0) && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        rd_en   = 1'b0;
        rd_node = node_reg;
        wr_en   = 1'b0;
        wr_addr = IDX_W'(wr_node_reg - PW'(1));
        wr_data = WEIGHT_BITS'(rd_data + delta_reg);
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_SUM:
            begin
                rd_en = (node_reg != '0);
            end
            ST_ADD:
            begin
                // read the next node while the previous one is written back
                rd_en = node_in_lim;
                wr_en = pend_reg;
            end
            ST_FIND:
            begin
                rd_en   = (step_reg != '0);
                rd_node = take ? cand_plus : at_plus;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
        rd_addr = IDX_W'(rd_node - PW'(1));
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next       = cmd_reg;
        pend_next      = rd_en;
        node_next      = node_reg;
        wr_node_next   = node_reg;
        lim_next       = lim_reg;
        step_next      = step_reg;
        at_next        = at_reg;
        cand_next      = rd_node;
        cand_ok_next   = (rd_node <= lim_reg);
        acc_next       = acc_reg;
        delta_next     = delta_reg;
        want_next      = want_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_item.command;
                    node_next  = pos_c;
                    lim_next   = lim_c;
                    acc_next   = '0;
                    at_next    = '0;
                    delta_next = WEIGHT_BITS'(in_item.delta);
                    want_next  = WEIGHT_BITS'(in_item.target);
                end
            end
            ST_SUM:
            begin
                if (pend_reg)
                begin
                    acc_next = acc_reg + rd_data;
                end
                if (node_reg != '0)
                begin
                    // drop the lowest set bit
                    node_next = node_reg & (node_reg - PW'(1));
                end
            end
            ST_ADD:
            begin
                if (node_in_lim)
                begin
                    // climb by the lowest set bit
                    node_next = node_reg + (node_reg & (~node_reg + PW'(1)));
                end
            end
            ST_FIND_INIT:
            begin
                step_next = lim_msb;
            end
            ST_FIND:
            begin
                if (take)
                begin
                    at_next   = cand_reg;
                    want_next = want_reg - rd_data;
                end
                step_next = step_reg >> 1;
            end
            ST_DONE:
            begin
                if (result_load)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.prefix_total   = '0;
                    out_item_next.found_position = '0;
                    if (cmd_reg == CMD_SUM)
                    begin
                        out_item_next.prefix_total = IN_WEIGHT_BITS'(acc_reg);
                    end
                    if (cmd_reg == CMD_FIND)
                    begin
                        out_item_next.found_position = POS_BITS'(at_reg + PW'(1));
                    end
                end
            end
            default:
            begin
                cmd_next = cmd_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pend_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        node_reg     <= node_next;
        wr_node_reg  <= wr_node_next;
        lim_reg      <= lim_next;
        step_reg     <= step_next;
        at_reg       <= at_next;
        cand_reg     <= cand_next;
        cand_ok_reg  <= cand_ok_next;
        acc_reg      <= acc_next;
        delta_reg    <= delta_next;
        want_reg     <= want_next;
        out_item_reg <= out_item_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FTE_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr,
        "read and write hit the same node in one cycle")
    `FTE_ASSERT_NOW(a_add_within_limit, (state_reg == ST_ADD) && pend_reg,
        wr_node_reg <= lim_reg, "add wrote a node above the limit")
    `FTE_ASSERT_NOW(a_find_step_pow2, state_reg == ST_FIND, $onehot0(step_reg),
        "find step is not a power of two")
    `FTE_ASSERT_NEXT(a_accept_busy, accept, !in_ready,
        "item accepted while previous one still in flight")
    `FTE_ASSERT_NEXT(a_result_shown, result_load, out_valid && (state_reg == ST_IDLE),
        "result not presented after completion")

endmodule

`default_nettype wire
